@@ src/iad_pkg.sv @@
// shared types, constants and the microcode table of the imu averaging block
package iad_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 10;

    localparam int MAX_COUNT_RESET   = 1000;
    localparam int THRESHOLD_RESET   = 2949;
    localparam int HOLD_TICKS_RESET  = 500;

    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int TICK_BITS      = 32;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_COUNT  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HOLD_TICKS = 2'd2;

    // s_tuser bit positions
    localparam int IN_USER_BITS   = 3;
    localparam int USER_OP        = 0;
    localparam int USER_ACC_VALID = 1;
    localparam int USER_GYR_VALID = 2;
    localparam int OUT_USER_BITS  = 1;

    // averaging channels, in result order
    localparam int NUM_CH = 7;
    typedef logic [2:0] ch_t;
    localparam ch_t CH_ACC0   = 3'd0;
    localparam ch_t CH_GYRO0  = 3'd3;
    localparam ch_t CH_THRUST = 3'd6;

    typedef enum logic [2:0] {
        ACT_NOP,
        ACT_ACCUM,
        ACT_CH_CLEAR,
        ACT_DIV_START,
        ACT_DIV_STORE,
        ACT_FLAG,
        ACT_EMIT
    } act_t;

    typedef enum logic [2:0] {
        CND_NEVER,
        CND_ALWAYS,
        CND_NO_REQ,
        CND_PREDICT,
        CND_ANY_ZERO,
        CND_DIV_BUSY,
        CND_CH_MORE,
        CND_OUT_BUSY
    } cond_t;

    typedef logic [3:0] step_t;
    localparam step_t STEP_IDLE     = 4'd0;
    localparam step_t STEP_DISPATCH = 4'd1;
    localparam step_t STEP_ACCUM    = 4'd2;
    localparam step_t STEP_CHECK    = 4'd3;
    localparam step_t STEP_DIV_GO   = 4'd4;
    localparam step_t STEP_DIV_WAIT = 4'd5;
    localparam step_t STEP_DIV_SAVE = 4'd6;
    localparam step_t STEP_FLAG     = 4'd7;
    localparam step_t STEP_EMIT     = 4'd8;
    localparam step_t STEP_TAIL     = 4'd9;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        step_t target;
    } ucode_t;

    typedef struct packed {
        logic req;
        logic is_predict;
        logic any_zero;
        logic div_busy;
        logic ch_more;
        logic out_busy;
    } seq_status_t;

    typedef struct packed {
        logic is_predict;
        logic any_zero;
        logic ch_more;
    } dp_status_t;

    // control store: jump to target when the condition holds, else fall through
    function automatic ucode_t iad_ucode(input step_t step);
        ucode_t w;
        begin
            unique case (step)
                STEP_IDLE:     w = '{ACT_NOP,       CND_NO_REQ,   STEP_IDLE};
                STEP_DISPATCH: w = '{ACT_NOP,       CND_PREDICT,  STEP_CHECK};
                STEP_ACCUM:    w = '{ACT_ACCUM,     CND_ALWAYS,   STEP_IDLE};
                STEP_CHECK:    w = '{ACT_CH_CLEAR,  CND_ANY_ZERO, STEP_IDLE};
                STEP_DIV_GO:   w = '{ACT_DIV_START, CND_NEVER,    STEP_IDLE};
                STEP_DIV_WAIT: w = '{ACT_NOP,       CND_DIV_BUSY, STEP_DIV_WAIT};
                STEP_DIV_SAVE: w = '{ACT_DIV_STORE, CND_CH_MORE,  STEP_DIV_GO};
                STEP_FLAG:     w = '{ACT_FLAG,      CND_NEVER,    STEP_IDLE};
                STEP_EMIT:     w = '{ACT_EMIT,      CND_OUT_BUSY, STEP_EMIT};
                STEP_TAIL:     w = '{ACT_NOP,       CND_ALWAYS,   STEP_IDLE};
                default:       w = '{ACT_NOP,       CND_ALWAYS,   STEP_IDLE};
            endcase
            return w;
        end
    endfunction

endpackage

@@ src/iad_seq.sv @@
// microcode sequencer: step counter, control store lookup and jump logic
module iad_seq
    import iad_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  seq_status_t status,
    output act_t        act,
    output logic        idle
);

    step_t  step_reg, step_next;
    ucode_t uword;
    logic   take;

    assign uword = iad_ucode(step_reg);
    assign act   = uword.act;
    assign idle  = (step_reg == STEP_IDLE);

    always_comb begin
        unique case (uword.cond)
            CND_NEVER:    take = 1'b0;
            CND_ALWAYS:   take = 1'b1;
            CND_NO_REQ:   take = !status.req;
            CND_PREDICT:  take = status.is_predict;
            CND_ANY_ZERO: take = status.any_zero;
            CND_DIV_BUSY: take = status.div_busy;
            CND_CH_MORE:  take = status.ch_more;
            CND_OUT_BUSY: take = status.out_busy;
            default:      take = 1'b0;
        endcase
        step_next = take ? uword.target : step_t'(step_reg + step_t'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

@@ src/iad_div.sv @@
// restoring unsigned divider, one quotient bit per cycle
module iad_div #(
    parameter int DIVIDEND_BITS = 26,
    parameter int DIVISOR_BITS  = 10
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [DIVIDEND_BITS-1:0] dividend,
    input  logic [DIVISOR_BITS-1:0]  divisor,
    output logic                     busy,
    output logic [DIVIDEND_BITS-1:0] quotient
);

    localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

    logic [DIVISOR_BITS-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_BITS-1:0] quo_reg, quo_next;
    logic [DIVISOR_BITS-1:0]  dvs_reg;
    logic [CNT_BITS-1:0]      cnt_reg;
    logic [DIVISOR_BITS:0]    trial;
    logic                     fits;

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

    always_comb begin
        trial    = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
        fits     = (trial >= {1'b0, dvs_reg});
        rem_next = fits ? DIVISOR_BITS'(trial - {1'b0, dvs_reg})
                        : trial[DIVISOR_BITS-1:0];
        quo_next = {quo_reg[DIVIDEND_BITS-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CNT_BITS'(DIVIDEND_BITS);
        end else if (busy) begin
            cnt_reg <= cnt_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

endmodule

@@ src/iad_dp.sv @@
// datapath: sums, counts, channel select for division, averages and flight flag
module iad_dp
    import iad_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    localparam int SUM_BITS   = SAMPLE_BITS + COUNT_BITS,
    localparam int IN_BITS    = NUM_CH * SAMPLE_BITS + TICK_BITS,
    localparam int RES_BITS   = NUM_CH * SAMPLE_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  act_t                      act,
    input  logic [IN_BITS-1:0]        in_data,
    input  logic [IN_USER_BITS-1:0]   in_user,
    input  logic [COUNT_BITS-1:0]     max_count,
    input  logic [CFG_DATA_BITS-1:0]  thrust_threshold,
    input  logic [CFG_DATA_BITS-1:0]  flight_hold_ticks,
    input  logic [SUM_BITS-1:0]       div_quotient,
    output logic [SUM_BITS-1:0]       div_dividend,
    output logic [COUNT_BITS-1:0]     div_divisor,
    output dp_status_t                status,
    output logic [RES_BITS-1:0]       res_data,
    output logic                      res_flying
);

    localparam int CMP_BITS = (SUM_BITS > CFG_DATA_BITS) ? SUM_BITS : CFG_DATA_BITS;

    logic [SAMPLE_BITS-1:0] acc_in [3];
    logic [SAMPLE_BITS-1:0] gyro_in [3];
    logic [SAMPLE_BITS-1:0] thr_in;
    logic [TICK_BITS-1:0]   tick_in;

    logic [SUM_BITS-1:0]    acc_sum_reg [3];
    logic [SUM_BITS-1:0]    gyro_sum_reg [3];
    logic [SUM_BITS-1:0]    thr_sum_reg;
    logic [COUNT_BITS-1:0]  acc_cnt_reg, gyro_cnt_reg, thr_cnt_reg;
    logic [TICK_BITS-1:0]   last_tick_reg, last_tick_next;
    logic                   flying_reg, flying_next;
    ch_t                    ch_reg;
    logic                   neg_reg;
    logic [SAMPLE_BITS-1:0] avg_reg [NUM_CH];

    logic                   acc_ok, gyro_ok, thr_ok;
    logic [SUM_BITS-1:0]    sel_sum;
    logic                   sel_signed, sel_neg;
    logic [1:0]             lane;
    logic [SUM_BITS-1:0]    q_signed;
    logic                   hit;

    for (genvar i = 0; i < 3; i++) begin : g_unpack
        assign acc_in[i]  = in_data[i*SAMPLE_BITS +: SAMPLE_BITS];
        assign gyro_in[i] = in_data[(i+3)*SAMPLE_BITS +: SAMPLE_BITS];
    end
    assign thr_in  = in_data[6*SAMPLE_BITS +: SAMPLE_BITS];
    assign tick_in = in_data[NUM_CH*SAMPLE_BITS +: TICK_BITS];

    for (genvar i = 0; i < NUM_CH; i++) begin : g_pack
        assign res_data[i*SAMPLE_BITS +: SAMPLE_BITS] = avg_reg[i];
    end
    assign res_flying = flying_reg;

    assign acc_ok  = in_user[USER_ACC_VALID] && (acc_cnt_reg < max_count);
    assign gyro_ok = in_user[USER_GYR_VALID] && (gyro_cnt_reg < max_count);
    assign thr_ok  = (thr_cnt_reg < max_count);

    assign status.is_predict = in_user[USER_OP];
    assign status.any_zero   = (acc_cnt_reg == '0) || (gyro_cnt_reg == '0)
                             || (thr_cnt_reg == '0);
    assign status.ch_more    = (ch_reg != CH_THRUST);

    // pick the sum and count for the channel being divided
    always_comb begin
        if (ch_reg < CH_GYRO0) begin
            lane        = ch_reg[1:0];
            sel_sum     = acc_sum_reg[lane];
            div_divisor = acc_cnt_reg;
            sel_signed  = 1'b1;
        end else if (ch_reg < CH_THRUST) begin
            lane        = 2'(ch_reg - CH_GYRO0);
            sel_sum     = gyro_sum_reg[lane];
            div_divisor = gyro_cnt_reg;
            sel_signed  = 1'b1;
        end else begin
            lane        = 2'(CH_ACC0);
            sel_sum     = thr_sum_reg;
            div_divisor = thr_cnt_reg;
            sel_signed  = 1'b0;
        end
        sel_neg      = sel_signed && sel_sum[SUM_BITS-1];
        div_dividend = sel_neg ? SUM_BITS'(-sel_sum) : sel_sum;
    end

    // truncation toward zero: divide magnitudes, then restore the sign
    assign q_signed = neg_reg ? SUM_BITS'(-div_quotient) : div_quotient;

    always_comb begin
        hit            = CMP_BITS'(avg_reg[CH_THRUST]) > CMP_BITS'(thrust_threshold);
        last_tick_next = hit ? tick_in : last_tick_reg;
        flying_next    = TICK_BITS'(tick_in - last_tick_next)
                       < TICK_BITS'(flight_hold_ticks);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                acc_sum_reg[i]  <= '0;
                gyro_sum_reg[i] <= '0;
            end
            thr_sum_reg   <= '0;
            acc_cnt_reg   <= '0;
            gyro_cnt_reg  <= '0;
            thr_cnt_reg   <= '0;
            last_tick_reg <= '0;
            flying_reg    <= 1'b0;
            ch_reg        <= CH_ACC0;
        end else begin
            unique case (act)
                ACT_ACCUM: begin
                    if (acc_ok) begin
                        for (int i = 0; i < 3; i++) begin
                            acc_sum_reg[i] <= acc_sum_reg[i]
                                + {{COUNT_BITS{acc_in[i][SAMPLE_BITS-1]}}, acc_in[i]};
                        end
                        acc_cnt_reg <= acc_cnt_reg + COUNT_BITS'(1);
                    end
                    if (gyro_ok) begin
                        for (int i = 0; i < 3; i++) begin
                            gyro_sum_reg[i] <= gyro_sum_reg[i]
                                + {{COUNT_BITS{gyro_in[i][SAMPLE_BITS-1]}}, gyro_in[i]};
                        end
                        gyro_cnt_reg <= gyro_cnt_reg + COUNT_BITS'(1);
                    end
                    if (thr_ok) begin
                        thr_sum_reg <= thr_sum_reg + {{COUNT_BITS{1'b0}}, thr_in};
                        thr_cnt_reg <= thr_cnt_reg + COUNT_BITS'(1);
                    end
                end
                ACT_CH_CLEAR: begin
                    ch_reg <= CH_ACC0;
                end
                ACT_DIV_STORE: begin
                    ch_reg <= ch_reg + ch_t'(1);
                end
                ACT_FLAG: begin
                    for (int i = 0; i < 3; i++) begin
                        acc_sum_reg[i]  <= '0;
                        gyro_sum_reg[i] <= '0;
                    end
                    thr_sum_reg   <= '0;
                    acc_cnt_reg   <= '0;
                    gyro_cnt_reg  <= '0;
                    thr_cnt_reg   <= '0;
                    last_tick_reg <= last_tick_next;
                    flying_reg    <= flying_next;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (act == ACT_DIV_START) begin
            neg_reg <= sel_neg;
        end
        if (act == ACT_DIV_STORE) begin
            avg_reg[ch_reg] <= q_signed[SAMPLE_BITS-1:0];
        end
    end

endmodule

@@ src/imu_accumulate_average.sv @@
// top level: stream ports, configuration registers, result register
//
// Sample requests (s_tuser op bit low) add the accelerometer and gyro triples
// when flagged valid, and always the thrust, into sums that stop growing once
// their own count reaches max_count. A predict request with any count at zero
// gives nothing. Otherwise the seven averages come from one shared restoring
// divider that yields one quotient bit a cycle, and a predict may also wait
// for m_tready on the previous result. The result then sits in an output
// register while the next request is taken. Configuration writes are always
// accepted and belong to idle periods.
module imu_accumulate_average
    import iad_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    localparam int SUM_BITS   = SAMPLE_BITS + COUNT_BITS,
    localparam int IN_BITS    = NUM_CH * SAMPLE_BITS + TICK_BITS,
    localparam int RES_BITS   = NUM_CH * SAMPLE_BITS,
    localparam int S_TDATA_W  = ((IN_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W  = ((RES_BITS + 7) / 8) * 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z, thrust, tick
    input  logic [S_TDATA_W-1:0]      s_tdata,
    // op, acc_valid, gyro_valid
    input  logic [IN_USER_BITS-1:0]   s_tuser,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // acc_avg_x, acc_avg_y, acc_avg_z, gyro_avg_x, gyro_avg_y, gyro_avg_z, thrust_avg
    output logic [M_TDATA_W-1:0]      m_tdata,
    // flying
    output logic [OUT_USER_BITS-1:0]  m_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam logic [COUNT_BITS-1:0] MAX_RST = COUNT_BITS'(MAX_COUNT_RESET);

    logic [COUNT_BITS-1:0]    max_count_reg;
    logic [CFG_DATA_BITS-1:0] threshold_reg;
    logic [CFG_DATA_BITS-1:0] hold_reg;

    logic [IN_BITS-1:0]       in_data_reg;
    logic [IN_USER_BITS-1:0]  in_user_reg;

    logic                     m_tvalid_reg;
    logic [M_TDATA_W-1:0]     m_tdata_reg;
    logic [OUT_USER_BITS-1:0] m_tuser_reg;

    act_t                     act;
    logic                     idle;
    seq_status_t              seq_status;
    dp_status_t               dp_status;
    logic                     div_busy;
    logic [SUM_BITS-1:0]      div_dividend, div_quotient;
    logic [COUNT_BITS-1:0]    div_divisor;
    logic [RES_BITS-1:0]      res_data;
    logic                     res_flying;
    logic                     out_busy, out_load;

    assign cfg_ready = 1'b1;
    assign s_tready  = idle;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    assign out_busy = m_tvalid_reg && !m_tready;
    assign out_load = (act == ACT_EMIT) && !out_busy;

    assign seq_status = '{
        req:        s_tvalid,
        is_predict: dp_status.is_predict,
        any_zero:   dp_status.any_zero,
        div_busy:   div_busy,
        ch_more:    dp_status.ch_more,
        out_busy:   out_busy
    };

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_count_reg <= MAX_RST;
            threshold_reg <= CFG_DATA_BITS'(THRESHOLD_RESET);
            hold_reg      <= CFG_DATA_BITS'(HOLD_TICKS_RESET);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MAX_COUNT:  max_count_reg <= COUNT_BITS'(cfg_data);
                CFG_THRESHOLD:  threshold_reg <= cfg_data;
                CFG_HOLD_TICKS: hold_reg      <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata[IN_BITS-1:0];
            in_user_reg <= s_tuser;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= M_TDATA_W'(res_data);
            m_tuser_reg <= OUT_USER_BITS'(res_flying);
        end
    end

    iad_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (seq_status),
        .act     (act),
        .idle    (idle)
    );

    iad_div #(
        .DIVIDEND_BITS (SUM_BITS),
        .DIVISOR_BITS  (COUNT_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (act == ACT_DIV_START),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    iad_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .act               (act),
        .in_data           (in_data_reg),
        .in_user           (in_user_reg),
        .max_count         (max_count_reg),
        .thrust_threshold  (threshold_reg),
        .flight_hold_ticks (hold_reg),
        .div_quotient      (div_quotient),
        .div_dividend      (div_dividend),
        .div_divisor       (div_divisor),
        .status            (dp_status),
        .res_data          (res_data),
        .res_flying        (res_flying)
    );

`ifndef SYNTHESIS
    // no new request while a division is still running
    a_idle_div: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_busy)
        else $error("request accepted while divider busy");

    // the zero-count check must have screened every division
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (act == ACT_DIV_START) |-> (div_divisor != '0))
        else $error("division started with zero count");

    // a result only appears from the emit step
    a_emit_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(act == ACT_EMIT))
        else $error("result raised outside emit step");
`endif

endmodule
